>>> rtl/sdd_pkg.sv
`default_nettype none
// ============================================================================
// sdd_pkg
// Types, constants and the microcode table shared by the serial day to date
// converter and its sequencer.
// ============================================================================
package sdd_pkg;

    // Calendar span covered by the converter.
    localparam logic [11:0] FIRST_YEAR    = 12'd1900;
    localparam logic [7:0]  LAST_YEAR_OFF = 8'd199;        // 2099 - 1900
    localparam logic [16:0] LAST_DAY      = 17'd73049;     // 2099-12-31
    localparam logic [3:0]  LAST_MONTH_IX = 4'd11;         // December, from 0
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [8:0]  LEAP_DAYS     = 9'd366;

    // Step counter values, which are also the microcode addresses.
    typedef logic [1:0] t_step;
    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_YEAR  = 2'd1;
    localparam t_step STEP_MONTH = 2'd2;
    localparam t_step STEP_EMIT  = 2'd3;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    // Condition that decides the jump of a control word.
    typedef enum logic [1:0] {
        CC_ALWAYS,
        CC_START,
        CC_YEAR,
        CC_MONTH
    } t_cond;

    // One control word of the microprogram.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jmp_true;
        t_step jmp_false;
        logic  busy;
    } t_uword;

    // Status flags reported by the datapath to the sequencer.
    typedef struct packed {
        logic year_more;
        logic month_more;
    } t_flags;

    // Controls driven by the sequencer into the datapath.
    typedef struct packed {
        t_op  op;
        logic en;
        logic busy;
    } t_ctrl;

    // The microprogram: load, strip whole years, strip months, present the word.
    function automatic t_uword ucode_rom(input t_step s);
        t_uword w;
        w = '{op: OP_NOP, cond: CC_ALWAYS, jmp_true: STEP_IDLE,
              jmp_false: STEP_IDLE, busy: 1'b0};
        case (s)
            STEP_IDLE: begin
                w = '{op: OP_LOAD, cond: CC_START, jmp_true: STEP_YEAR,
                      jmp_false: STEP_IDLE, busy: 1'b0};
            end
            STEP_YEAR: begin
                w = '{op: OP_YEAR, cond: CC_YEAR, jmp_true: STEP_YEAR,
                      jmp_false: STEP_MONTH, busy: 1'b1};
            end
            STEP_MONTH: begin
                w = '{op: OP_MONTH, cond: CC_MONTH, jmp_true: STEP_MONTH,
                      jmp_false: STEP_EMIT, busy: 1'b1};
            end
            STEP_EMIT: begin
                w = '{op: OP_EMIT, cond: CC_ALWAYS, jmp_true: STEP_IDLE,
                      jmp_false: STEP_IDLE, busy: 1'b1};
            end
            default: begin
                w = '{op: OP_NOP, cond: CC_ALWAYS, jmp_true: STEP_IDLE,
                      jmp_false: STEP_IDLE, busy: 1'b1};
            end
        endcase
        return w;
    endfunction

    // Length of a month, indexed from 0 for January.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1:                     len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> rtl/sdd_seq.sv
`default_nettype none
// ============================================================================
// sdd_seq
// Microcode sequencer: a step counter addressing the control table, with a
// conditional jump chosen by the datapath flags or the start request.
// ============================================================================
module sdd_seq
    import sdd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_flags i_flags,
    output t_ctrl       o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_cond;

    // Fetch the control word and evaluate its condition.
    always_comb begin
        w_word = ucode_rom(r_step);
        case (w_word.cond)
            CC_ALWAYS: w_cond = 1'b1;
            CC_START:  w_cond = i_start;
            CC_YEAR:   w_cond = i_flags.year_more;
            CC_MONTH:  w_cond = i_flags.month_more;
            default:   w_cond = 1'b0;
        endcase
        n_step = w_cond ? w_word.jmp_true : w_word.jmp_false;
    end

    // Controls for the datapath.
    assign o_ctrl = '{op: w_word.op, en: w_cond, busy: w_word.busy};

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

>>> rtl/serial_day_to_date.sv
`default_nettype none
// ============================================================================
// serial_day_to_date
// Converts a serial day count (1 is 1900-01-01) into a Gregorian date,
// clamped to 1900-01-01 .. 2099-12-31, using a small microcoded sequencer.
// ============================================================================
// Y (0..199) is the number of whole years and M (0..11) the number of whole
// months taken off. The year and month steps each take off one year or one
// month per cycle. A new word is taken only while busy is low; busy is high
// until the result is out, and the receiver cannot stall it.
// Reset: synchronous, active low; clears the step counter and the strobe.
// ============================================================================
module serial_day_to_date
    import sdd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic signed [17:0] i_day_number,
    output logic                    busy,
    output logic                    o_valid,
    output logic [11:0]             o_year,
    output logic [3:0]              o_month,
    output logic [4:0]              o_day_of_month,
    output logic                    o_saturated
);

    t_ctrl      w_ctrl;
    t_flags     w_flags;

    logic [16:0] r_rem;
    logic [7:0]  r_yoff;
    logic [3:0]  r_moff;
    logic        r_sat;
    logic        r_valid;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;

    // Sequencer.
    sdd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign busy = w_ctrl.busy;

    // Leap rule over 1900..2099: a multiple of four, except 1900 itself.
    assign w_leap = (r_yoff[1:0] == 2'b00) && (r_yoff != 8'd0);
    assign w_ylen = w_leap ? LEAP_DAYS : YEAR_DAYS;
    assign w_mlen = month_len(r_moff, w_leap);

    // Flags telling the sequencer whether another year or month comes off.
    always_comb begin
        w_flags.year_more  = (r_rem > {8'd0, w_ylen}) && (r_yoff != LAST_YEAR_OFF);
        w_flags.month_more = (r_moff != LAST_MONTH_IX) && (r_rem > {12'd0, w_mlen});
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.en) begin
            case (w_ctrl.op)
                OP_LOAD: begin
                    r_yoff <= 8'd0;
                    r_moff <= 4'd0;
                    if (i_day_number < 18'sd1) begin
                        r_rem <= 17'd1;
                        r_sat <= 1'b1;
                    end else if (i_day_number > $signed({1'b0, LAST_DAY})) begin
                        r_rem <= LAST_DAY;
                        r_sat <= 1'b1;
                    end else begin
                        r_rem <= i_day_number[16:0];
                        r_sat <= 1'b0;
                    end
                end
                OP_YEAR: begin
                    r_rem  <= r_rem - {8'd0, w_ylen};
                    r_yoff <= r_yoff + 8'd1;
                end
                OP_MONTH: begin
                    r_rem  <= r_rem - {12'd0, w_mlen};
                    r_moff <= r_moff + 4'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.op == OP_EMIT) begin
            o_year         <= FIRST_YEAR + {4'd0, r_yoff};
            o_month        <= r_moff + 4'd1;
            o_day_of_month <= r_rem[4:0];
            o_saturated    <= r_sat;
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (w_ctrl.op == OP_EMIT);
        end
    end

    assign o_valid = r_valid;

    // An accepted word makes the block busy on the next cycle.
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // The remaining day count never reaches zero while converting.
    a_rem_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_rem != 17'd0))
        else $error("remaining day count reached zero");

    // Every result is a real calendar position.
    a_result_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month != 4'd0 && o_month <= 4'd12 && o_day_of_month != 5'd0
                     && o_year >= 12'd1900 && o_year <= 12'd2099))
        else $error("result date out of range");

    // The strobe follows only the emit step, which is busy.
    a_strobe_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result strobe without a conversion");

endmodule
`default_nettype wire
